// ===== sv/i2cme_pkg.sv =====
`default_nettype none
package i2cme_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 2;

  localparam int HP_RESET  = 100;
  localparam int TMO_RESET = 1000000;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_PERIOD = 2'd0,
    REG_TIMEOUT     = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_START   = 3'd1,
    OP_RESTART = 3'd2,
    OP_STOP    = 3'd3,
    OP_WRITE   = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_ACK     = 2'd0,
    ST_NACK    = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST1, PH_ST2,
    PH_WB_D1, PH_WB_W, PH_WB_D2,
    PH_WA_D1, PH_WA_W, PH_WA_D2,
    PH_RS1, PH_RS2, PH_RS3, PH_RS4, PH_RS5,
    PH_SP1, PH_SP2, PH_SP3, PH_SP4, PH_SP5,
    PH_RB_D1, PH_RB_W, PH_RB_D2, PH_RB_W2,
    PH_RA_D1, PH_RA_W, PH_RA_D2, PH_RA_W2, PH_RA_D3
  } phase_t;

  // packed MSB first, so operation lands in the lowest bits of tdata
  typedef struct packed {
    logic       sda_in;
    logic       scl_in;
    logic       allow_stretch;
    logic       send_ack;
    logic [7:0] data_byte;
    logic [2:0] operation;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
    logic       done_res;
    logic       ready_res;
    logic       sda_drive_low;
    logic       scl_drive_low;
  } tick_res_t;

  function automatic logic is_wait(input phase_t p);
    return (p == PH_WB_W)  || (p == PH_WA_W)  || (p == PH_RS3)   || (p == PH_SP3) ||
           (p == PH_RB_W)  || (p == PH_RB_W2) || (p == PH_RA_W)  || (p == PH_RA_W2);
  endfunction

endpackage
`default_nettype wire

// ===== sv/i2cme_core.sv =====
`default_nettype none
module i2cme_core #(
  parameter int DELAY_WIDTH   = 16,
  parameter int TIMEOUT_WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  i2cme_pkg::item_t         item,
  input  logic [DELAY_WIDTH-1:0]   half_period,
  input  logic [TIMEOUT_WIDTH-1:0] timeout_lim,
  output i2cme_pkg::tick_res_t     res
);
  import i2cme_pkg::*;

  phase_t                   phase_r, phase_nxt;
  logic [3:0]               bit_cnt_r, bit_cnt_nxt;
  logic [7:0]               shift_r, shift_nxt;
  logic [DELAY_WIDTH-1:0]   dly_r, dly_nxt;
  logic [TIMEOUT_WIDTH-1:0] tmo_r, tmo_nxt;
  logic                     scl_r, scl_nxt;
  logic                     sda_r, sda_nxt;
  logic [1:0]               status_r, status_nxt;
  logic                     opt_r, opt_nxt;
  logic [7:0]               rx_r, rx_nxt;

  logic [DELAY_WIDTH-1:0]   hp_eff;
  logic [TIMEOUT_WIDTH-1:0] tmo_inc;
  logic                     adv;
  logic                     done;

  assign hp_eff  = (half_period == '0) ? DELAY_WIDTH'(1) : half_period;
  assign tmo_inc = (tmo_r != '1) ? tmo_r + TIMEOUT_WIDTH'(1) : tmo_r;

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    dly_nxt     = dly_r;
    tmo_nxt     = tmo_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    status_nxt  = status_r;
    opt_nxt     = opt_r;
    rx_nxt      = rx_r;
    adv         = 1'b0;
    done        = 1'b0;
    if (fire) begin
      if (phase_r == PH_IDLE) begin
        tmo_nxt     = '0;
        bit_cnt_nxt = '0;
        unique case (op_t'(item.operation))
          OP_START: begin
            shift_nxt = item.data_byte;
            sda_nxt   = 1'b1;
            dly_nxt   = hp_eff;
            phase_nxt = PH_ST1;
          end
          OP_RESTART: begin
            shift_nxt = item.data_byte;
            scl_nxt   = 1'b1;
            dly_nxt   = hp_eff;
            phase_nxt = PH_RS1;
          end
          OP_STOP: begin
            opt_nxt   = item.allow_stretch;
            scl_nxt   = 1'b1;
            dly_nxt   = hp_eff;
            phase_nxt = PH_SP1;
          end
          OP_WRITE: begin
            shift_nxt = item.data_byte;
            scl_nxt   = 1'b1;
            sda_nxt   = ~item.data_byte[7];
            dly_nxt   = hp_eff;
            phase_nxt = PH_WB_D1;
          end
          OP_READ: begin
            shift_nxt = '0;
            opt_nxt   = item.send_ack;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b0;
            dly_nxt   = hp_eff;
            phase_nxt = PH_RB_D1;
          end
          default: ;
        endcase
      end else begin
        tmo_nxt = tmo_inc;
        if (tmo_inc >= timeout_lim) begin
          scl_nxt    = 1'b0;
          sda_nxt    = 1'b0;
          status_nxt = ST_TIMEOUT;
          phase_nxt  = PH_IDLE;
          done       = 1'b1;
        end else if (is_wait(phase_r)) begin
          adv = item.scl_in;
        end else begin
          dly_nxt = dly_r - DELAY_WIDTH'(1);
          adv     = (dly_nxt == '0);
        end
      end

      if (adv) begin
        unique case (phase_r)
          PH_ST1: begin
            scl_nxt = 1'b1; dly_nxt = hp_eff; phase_nxt = PH_ST2;
          end
          PH_ST2, PH_RS5: begin
            scl_nxt = 1'b1; sda_nxt = ~shift_r[7]; dly_nxt = hp_eff; phase_nxt = PH_WB_D1;
          end
          PH_WB_D1: begin
            scl_nxt = 1'b0; phase_nxt = PH_WB_W;
          end
          PH_WB_W: begin
            dly_nxt = hp_eff; phase_nxt = PH_WB_D2;
          end
          PH_WB_D2: begin
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_cnt_nxt = bit_cnt_r + 4'd1;
            scl_nxt     = 1'b1;
            dly_nxt     = hp_eff;
            if (bit_cnt_nxt < BITS_PER_BYTE) begin
              sda_nxt   = ~shift_r[6];
              phase_nxt = PH_WB_D1;
            end else begin
              sda_nxt   = 1'b0;
              phase_nxt = PH_WA_D1;
            end
          end
          PH_WA_D1: begin
            scl_nxt = 1'b0; phase_nxt = PH_WA_W;
          end
          PH_WA_W: begin
            status_nxt = item.sda_in ? ST_NACK : ST_ACK;
            dly_nxt    = hp_eff;
            phase_nxt  = PH_WA_D2;
          end
          PH_WA_D2: begin
            scl_nxt = 1'b1; phase_nxt = PH_IDLE; done = 1'b1;
          end
          PH_RS1: begin
            sda_nxt = 1'b0; dly_nxt = hp_eff; phase_nxt = PH_RS2;
          end
          PH_RS2: begin
            scl_nxt = 1'b0; phase_nxt = PH_RS3;
          end
          PH_RS3: begin
            dly_nxt = hp_eff; phase_nxt = PH_RS4;
          end
          PH_RS4: begin
            sda_nxt = 1'b1; dly_nxt = hp_eff; phase_nxt = PH_RS5;
          end
          PH_SP1: begin
            sda_nxt = 1'b1; dly_nxt = hp_eff; phase_nxt = PH_SP2;
          end
          PH_SP2: begin
            scl_nxt = 1'b0;
            if (opt_r) begin
              phase_nxt = PH_SP3;
            end else begin
              dly_nxt = hp_eff; phase_nxt = PH_SP4;
            end
          end
          PH_SP3: begin
            dly_nxt = hp_eff; phase_nxt = PH_SP4;
          end
          PH_SP4: begin
            sda_nxt = 1'b0; dly_nxt = hp_eff; phase_nxt = PH_SP5;
          end
          PH_SP5: begin
            status_nxt = ST_ACK; phase_nxt = PH_IDLE; done = 1'b1;
          end
          PH_RB_D1: begin
            scl_nxt = 1'b0; phase_nxt = PH_RB_W;
          end
          PH_RB_W: begin
            dly_nxt = hp_eff; phase_nxt = PH_RB_D2;
          end
          PH_RB_D2: begin
            phase_nxt = PH_RB_W2;
          end
          PH_RB_W2: begin
            shift_nxt   = {shift_r[6:0], item.sda_in};
            bit_cnt_nxt = bit_cnt_r + 4'd1;
            scl_nxt     = 1'b1;
            dly_nxt     = hp_eff;
            if (bit_cnt_nxt < BITS_PER_BYTE) begin
              sda_nxt   = 1'b0;
              phase_nxt = PH_RB_D1;
            end else begin
              sda_nxt   = opt_r;
              phase_nxt = PH_RA_D1;
            end
          end
          PH_RA_D1: begin
            scl_nxt = 1'b0; phase_nxt = PH_RA_W;
          end
          PH_RA_W: begin
            dly_nxt = hp_eff; phase_nxt = PH_RA_D2;
          end
          PH_RA_D2: begin
            phase_nxt = PH_RA_W2;
          end
          PH_RA_W2: begin
            dly_nxt = hp_eff; phase_nxt = PH_RA_D3;
          end
          PH_RA_D3: begin
            scl_nxt    = 1'b1;
            rx_nxt     = shift_r;
            status_nxt = ST_ACK;
            phase_nxt  = PH_IDLE;
            done       = 1'b1;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      dly_r     <= '0;
      tmo_r     <= '0;
      scl_r     <= 1'b0;
      sda_r     <= 1'b0;
      status_r  <= ST_ACK;
      opt_r     <= 1'b0;
      rx_r      <= '0;
    end else begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      dly_r     <= dly_nxt;
      tmo_r     <= tmo_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      status_r  <= status_nxt;
      opt_r     <= opt_nxt;
      rx_r      <= rx_nxt;
    end
  end

  always_comb begin
    res.scl_drive_low = scl_nxt;
    res.sda_drive_low = sda_nxt;
    res.ready_res     = (phase_nxt == PH_IDLE);
    res.done_res      = done;
    res.status        = status_nxt;
    res.read_data     = rx_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/i2c_master_byte_engine_unit.sv =====
`default_nettype none
// Open-drain I2C master byte engine. Every input transfer is one bus tick: it
// carries an optional command (start, repeated start, stop, write byte, read
// byte) and the sampled SCL/SDA levels, and yields exactly one result transfer
// with the line drive levels, ready, a done pulse, status and the last read
// byte. Commands arriving while busy are dropped. One transfer is taken per
// cycle unless the output stalls; a result passes through the input register,
// then the phase sequencer feeding the result register. cfg_index 0 sets the
// half-period tick count (0 acts as 1), index 1 the per-command timeout.
module i2c_master_byte_engine_unit #(
  parameter int DELAY_WIDTH   = 16,
  parameter int TIMEOUT_WIDTH = 24,
  localparam int CFG_W = (DELAY_WIDTH > TIMEOUT_WIDTH) ? DELAY_WIDTH : TIMEOUT_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // operation[2:0], data_byte[10:3], send_ack[11], allow_stretch[12],
  // scl_in[13], sda_in[14], zero[15]
  input  logic [i2cme_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // scl_drive_low[0], sda_drive_low[1], ready_res[2], done_res[3],
  // status[5:4], read_data[13:6], zero[15:14]
  output logic [i2cme_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                               cfg_we,
  input  logic [i2cme_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]                   cfg_data
);
  import i2cme_pkg::*;

  logic [DELAY_WIDTH-1:0]   hp_r;
  logic [TIMEOUT_WIDTH-1:0] tmo_lim_r;
  logic                     in_v_r;
  item_t                    in_item_r;
  logic                     out_v_r;
  tick_res_t                out_res_r;
  tick_res_t                res;
  logic                     out_free;
  logic                     fire;

  assign out_free  = !out_v_r || out_tready;
  assign fire      = in_v_r && out_free;
  assign in_tready = !in_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r      <= DELAY_WIDTH'(HP_RESET);
      tmo_lim_r <= TIMEOUT_WIDTH'(TMO_RESET);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HALF_PERIOD: hp_r      <= cfg_data[DELAY_WIDTH-1:0];
        REG_TIMEOUT:     tmo_lim_r <= cfg_data[TIMEOUT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= in_tdata[$bits(item_t)-1:0];
    end
  end

  i2cme_core #(
    .DELAY_WIDTH   (DELAY_WIDTH),
    .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (in_item_r),
    .half_period (hp_r),
    .timeout_lim (tmo_lim_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(OUT_TDATA_W - $bits(tick_res_t))'(0), out_res_r};

endmodule
`default_nettype wire

// ===== sv/i2cme_checker.sv =====
`default_nettype none
module i2cme_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [i2cme_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import i2cme_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[2])
    else $error("done without ready");

  a_timeout_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] && (out_tdata[5:4] == ST_TIMEOUT) |-> (out_tdata[1:0] == 2'b00))
    else $error("lines held after timeout");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:4] != 2'b11) && (out_tdata[15:14] == 2'b00))
    else $error("bad status or pad bits");

  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("accepted transfer produced no result");

endmodule

bind i2c_master_byte_engine_unit i2cme_checker u_i2cme_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== sim/i2c_master_byte_engine_unit_tb.sv =====
`timescale 1ns / 1ps

module i2c_master_byte_engine_unit_tb;
  import i2cme_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int unsigned SQUEEZE_CYCLES = 400;

  typedef struct packed {
    phase_t      ph;
    logic [3:0]  nbits;
    logic [7:0]  sh;
    logic [15:0] dly;
    logic [23:0] tmo;
    logic        scl_lo;
    logic        sda_lo;
    logic [1:0]  st;
    logic        opt;
    logic [7:0]  rx;
  } engine_state_t;

  typedef struct packed {
    item_t     it;
    tick_res_t res;
  } bus_tick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  engine_state_t eng;
  logic [15:0] half_ticks;
  logic [23:0] tmo_limit;

  bus_tick_t pending_ticks[$];
  tick_res_t predicted_results[$];
  bus_tick_t drv_cur;
  tick_res_t last_res;

  int unsigned errors = 0;
  int unsigned rx_count = 0;
  int unsigned gen_count = 0;
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned hold_left = 0;
  int unsigned rx_calm = 0;
  int unsigned stretch_left = 0;
  phase_t last_wait_ph;
  logic squeeze_req = 1'b0;
  logic bus_open = 1'b0;

  i2c_master_byte_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic line_wait(input phase_t p);
    case (p)
      PH_WB_W, PH_WA_W, PH_RS3, PH_SP3, PH_RB_W, PH_RB_W2, PH_RA_W, PH_RA_W2: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void load_delay(input phase_t p);
    eng.dly = (half_ticks == '0) ? 16'd1 : half_ticks;
    eng.ph = p;
  endfunction

  function automatic void drive_wr_bit();
    eng.scl_lo = 1'b1;
    eng.sda_lo = ~eng.sh[7];
    load_delay(PH_WB_D1);
  endfunction

  function automatic void drive_rd_bit();
    eng.scl_lo = 1'b1;
    eng.sda_lo = 1'b0;
    load_delay(PH_RB_D1);
  endfunction

  // action taken when the current phase completes; returns 1 on command done
  function automatic logic step_phase(input logic sda);
    logic fin;
    fin = 1'b0;
    case (eng.ph)
      PH_ST1: begin
        eng.scl_lo = 1'b1;
        load_delay(PH_ST2);
      end
      PH_ST2: drive_wr_bit();
      PH_WB_D1: begin
        eng.scl_lo = 1'b0;
        eng.ph = PH_WB_W;
      end
      PH_WB_W: load_delay(PH_WB_D2);
      PH_WB_D2: begin
        eng.sh = eng.sh << 1;
        eng.nbits = eng.nbits + 4'd1;
        if (eng.nbits < BITS_PER_BYTE) begin
          drive_wr_bit();
        end else begin
          eng.scl_lo = 1'b1;
          eng.sda_lo = 1'b0;
          load_delay(PH_WA_D1);
        end
      end
      PH_WA_D1: begin
        eng.scl_lo = 1'b0;
        eng.ph = PH_WA_W;
      end
      PH_WA_W: begin
        eng.st = sda ? ST_NACK : ST_ACK;
        load_delay(PH_WA_D2);
      end
      PH_WA_D2: begin
        eng.scl_lo = 1'b1;
        eng.ph = PH_IDLE;
        fin = 1'b1;
      end
      PH_RS1: begin
        eng.sda_lo = 1'b0;
        load_delay(PH_RS2);
      end
      PH_RS2: begin
        eng.scl_lo = 1'b0;
        eng.ph = PH_RS3;
      end
      PH_RS3: load_delay(PH_RS4);
      PH_RS4: begin
        eng.sda_lo = 1'b1;
        load_delay(PH_RS5);
      end
      PH_RS5: drive_wr_bit();
      PH_SP1: begin
        eng.sda_lo = 1'b1;
        load_delay(PH_SP2);
      end
      PH_SP2: begin
        eng.scl_lo = 1'b0;
        if (eng.opt) eng.ph = PH_SP3;
        else load_delay(PH_SP4);
      end
      PH_SP3: load_delay(PH_SP4);
      PH_SP4: begin
        eng.sda_lo = 1'b0;
        load_delay(PH_SP5);
      end
      PH_SP5: begin
        eng.st = ST_ACK;
        eng.ph = PH_IDLE;
        fin = 1'b1;
      end
      PH_RB_D1: begin
        eng.scl_lo = 1'b0;
        eng.ph = PH_RB_W;
      end
      PH_RB_W: load_delay(PH_RB_D2);
      PH_RB_D2: eng.ph = PH_RB_W2;
      PH_RB_W2: begin
        eng.sh = {eng.sh[6:0], sda};
        eng.nbits = eng.nbits + 4'd1;
        if (eng.nbits < BITS_PER_BYTE) begin
          drive_rd_bit();
        end else begin
          eng.scl_lo = 1'b1;
          eng.sda_lo = eng.opt;
          load_delay(PH_RA_D1);
        end
      end
      PH_RA_D1: begin
        eng.scl_lo = 1'b0;
        eng.ph = PH_RA_W;
      end
      PH_RA_W: load_delay(PH_RA_D2);
      PH_RA_D2: eng.ph = PH_RA_W2;
      PH_RA_W2: load_delay(PH_RA_D3);
      PH_RA_D3: begin
        eng.scl_lo = 1'b1;
        eng.rx = eng.sh;
        eng.st = ST_ACK;
        eng.ph = PH_IDLE;
        fin = 1'b1;
      end
      default: eng.ph = PH_IDLE;
    endcase
    return fin;
  endfunction

  function automatic tick_res_t engine_tick(input item_t it);
    tick_res_t res;
    logic fin;
    fin = 1'b0;
    if (eng.ph == PH_IDLE) begin
      eng.tmo = '0;
      eng.nbits = '0;
      case (it.operation)
        OP_START: begin
          eng.sh = it.data_byte;
          eng.sda_lo = 1'b1;
          load_delay(PH_ST1);
        end
        OP_RESTART: begin
          eng.sh = it.data_byte;
          eng.scl_lo = 1'b1;
          load_delay(PH_RS1);
        end
        OP_STOP: begin
          eng.opt = it.allow_stretch;
          eng.scl_lo = 1'b1;
          load_delay(PH_SP1);
        end
        OP_WRITE: begin
          eng.sh = it.data_byte;
          drive_wr_bit();
        end
        OP_READ: begin
          eng.sh = '0;
          eng.opt = it.send_ack;
          drive_rd_bit();
        end
        default: ;
      endcase
    end else begin
      if (eng.tmo != '1) eng.tmo = eng.tmo + 24'd1;
      if (eng.tmo >= tmo_limit) begin
        eng.scl_lo = 1'b0;
        eng.sda_lo = 1'b0;
        eng.st = ST_TIMEOUT;
        eng.ph = PH_IDLE;
        fin = 1'b1;
      end else if (line_wait(eng.ph)) begin
        if (it.scl_in) fin = step_phase(it.sda_in);
      end else begin
        eng.dly = eng.dly - 16'd1;
        if (eng.dly == '0) fin = step_phase(it.sda_in);
      end
    end
    res.scl_drive_low = eng.scl_lo;
    res.sda_drive_low = eng.sda_lo;
    res.ready_res = (eng.ph == PH_IDLE);
    res.done_res = fin;
    res.status = eng.st;
    res.read_data = eng.rx;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one bus tick: random sampled line levels, with slave clock stretching in wait phases
  task automatic emit(input logic [2:0] op, input logic [7:0] data, input logic ack,
                      input logic stretch);
    bus_tick_t t;
    int unsigned r;
    t.it.operation = op;
    t.it.data_byte = data;
    t.it.send_ack = ack;
    t.it.allow_stretch = stretch;
    if (line_wait(eng.ph)) begin
      if (eng.ph != last_wait_ph) begin
        last_wait_ph = eng.ph;
        r = $urandom_range(0, 99);
        if (r < 60) stretch_left = 0;
        else if (r < 92) stretch_left = $urandom_range(1, 4);
        else stretch_left = $urandom_range(8, 24);
      end
      t.it.scl_in = (stretch_left == 0);
      if (stretch_left != 0) stretch_left--;
    end else begin
      last_wait_ph = PH_IDLE;
      t.it.scl_in = 1'($urandom);
    end
    t.it.sda_in = 1'($urandom);
    t.res = engine_tick(t.it);
    last_res = t.res;
    pending_ticks.push_back(t);
    gen_count++;
  endtask

  task automatic run_cmd(input logic [2:0] op, input logic [7:0] data, input logic ack,
                         input logic stretch);
    logic [2:0] busy_op;
    emit(op, data, ack, stretch);
    while (eng.ph != PH_IDLE) begin
      busy_op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : OP_NONE;
      emit(busy_op, 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic random_phase(input int unsigned n_ticks);
    int unsigned first;
    int unsigned r;
    logic [2:0] op;
    first = gen_count;
    while (gen_count - first < n_ticks) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        op = (r < 3) ? 3'($urandom_range(OP_SPARE_A, OP_SPARE_B)) : OP_NONE;
      end else if (!bus_open) begin
        op = (r < 28) ? 3'($urandom_range(OP_RESTART, OP_READ)) : OP_START;
      end else if (r < 50) begin
        op = OP_WRITE;
      end else if (r < 75) begin
        op = OP_READ;
      end else if (r < 83) begin
        op = OP_RESTART;
      end else begin
        op = OP_STOP;
      end
      run_cmd(op, 8'($urandom), 1'($urandom), 1'($urandom));
      if (op == OP_START || op == OP_RESTART) bus_open = 1'b1;
      else if (op == OP_STOP) bus_open = 1'b0;
      if (last_res.done_res && last_res.status == ST_TIMEOUT) bus_open = 1'b0;
    end
  endtask

  task automatic settle();
    while (pending_ticks.size() != 0 || predicted_results.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HALF_PERIOD) half_ticks = val[15:0];
    else if (idx == REG_TIMEOUT) tmo_limit = val;
  endtask

  task automatic set_regs(input logic [15:0] hp, input logic [23:0] tmo);
    settle();
    write_reg(REG_HALF_PERIOD, {8'd0, hp});
    write_reg(REG_TIMEOUT, tmo);
  endtask

  task automatic report(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h want %0h", rx_count, name, got, want));
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) predicted_results.push_back(drv_cur.res);
      if (in_gap != 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        drv_cur = pending_ticks.pop_front();
        in_tdata <= IN_TDATA_W'(drv_cur.it);
        in_tvalid <= 1'b1;
        if (in_calm != 0) begin
          in_calm--;
        end else if ($urandom_range(0, 99) < 2) begin
          in_calm = $urandom_range(50, 150);
        end else begin
          in_gap = pick_gap();
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    tick_res_t got;
    tick_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(tick_res_t)-1:0];
        if (predicted_results.size() == 0) begin
          report($sformatf("result %0d arrived with none pending", rx_count));
        end else begin
          want = predicted_results.pop_front();
          check_field("scl_drive_low", 8'(got.scl_drive_low), 8'(want.scl_drive_low));
          check_field("sda_drive_low", 8'(got.sda_drive_low), 8'(want.sda_drive_low));
          check_field("ready_res", 8'(got.ready_res), 8'(want.ready_res));
          check_field("done_res", 8'(got.done_res), 8'(want.done_res));
          check_field("status", 8'(got.status), 8'(want.status));
          check_field("read_data", got.read_data, want.read_data);
        end
        rx_count++;
      end
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_calm != 0) begin
        rx_calm--;
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        rx_calm = $urandom_range(50, 150);
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        hold_left = pick_gap();
        out_tready <= (hold_left == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    eng = '0;
    eng.ph = PH_IDLE;
    last_wait_ph = PH_IDLE;
    half_ticks = 16'(HP_RESET);
    tmo_limit = 24'(TMO_RESET);
    last_res = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // unknown register index must leave both registers alone
    write_reg(CFG_IDX_SPARE, 24'hFFFFFF);
    set_regs(16'd1, 24'hFFFFFF);

    run_cmd(OP_NONE, 8'h00, 1'b0, 1'b0);
    run_cmd(OP_SPARE_A, 8'hFF, 1'b1, 1'b1);
    run_cmd(OP_SPARE_B, 8'h00, 1'b0, 1'b0);
    run_cmd(OP_START, 8'hFF, 1'b0, 1'b1);
    run_cmd(OP_WRITE, 8'h00, 1'b1, 1'b0);
    run_cmd(OP_WRITE, 8'hA5, 1'b0, 1'b1);
    run_cmd(OP_READ, 8'hFF, 1'b1, 1'b0);
    run_cmd(OP_READ, 8'h00, 1'b0, 1'b1);
    run_cmd(OP_RESTART, 8'h00, 1'b1, 1'b0);
    run_cmd(OP_WRITE, 8'hFF, 1'b0, 1'b0);
    run_cmd(OP_STOP, 8'h3C, 1'b0, 1'b1);
    run_cmd(OP_STOP, 8'hC3, 1'b1, 1'b0);
    run_cmd(OP_START, 8'h00, 1'b1, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0, 1'b0);

    // zero half period behaves as one tick; zero timeout fires at once
    set_regs(16'd0, 24'hFFFFFF);
    run_cmd(OP_START, 8'h5A, 1'b0, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0, 1'b1);
    set_regs(16'd2, 24'd0);
    run_cmd(OP_WRITE, 8'h3C, 1'b1, 1'b0);

    // longest half period with a short timeout only ever ends in a timeout
    set_regs(16'hFFFF, 24'd1);
    run_cmd(OP_START, 8'h81, 1'b0, 1'b1);
    set_regs(16'hFFFF, 24'd30);
    run_cmd(OP_WRITE, 8'h7E, 1'b1, 1'b0);
    run_cmd(OP_READ, 8'h18, 1'b1, 1'b1);

    set_regs(16'd1, 24'hFFFFFF);
    bus_open = 1'b0;
    squeeze_req = 1'b1;
    random_phase(30);
    set_regs(16'd2, 24'd100000);
    random_phase(30);
    set_regs(16'd2, 24'd80);
    random_phase(30);
    set_regs(16'd1, 24'd40);
    random_phase(30);
    set_regs(16'd4, 24'd500);
    random_phase(30);

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/i2cme_pkg.sv
sv/i2cme_core.sv
sv/i2c_master_byte_engine_unit.sv
sv/i2cme_checker.sv
sim/i2c_master_byte_engine_unit_tb.sv
